[rtl/core/rwe_pkg.sv]
package rwe_pkg;

   localparam int unsigned EXP_TABLE_BITS = 10;
   localparam int unsigned EXP_FRAC_BITS  = 32 - EXP_TABLE_BITS;
   localparam int unsigned EXP_ROM_DEPTH  = (1 << EXP_TABLE_BITS) + 1;
   localparam int unsigned EXP_ADDR_BITS  = EXP_TABLE_BITS + 1;
   localparam int unsigned EXP_INT_DEPTH  = 64;

   localparam logic [1:0] MODE_PRIMITIVE  = 2'd0;
   localparam logic [1:0] MODE_WAVELET    = 2'd1;
   localparam logic [1:0] MODE_DERIVATIVE = 2'd2;

   localparam logic CSR_CENTRE_FREQUENCY = 1'b0;
   localparam logic CSR_PERIOD           = 1'b1;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] K2PI2  = (PI_Q30 * PI_Q30 + 64'd134217728) >> 28;

   // multiplying by this operand with this shift returns the other operand unchanged
   localparam logic [39:0] UNITY_A     = 40'd1 << 22;
   localparam logic [5:0]  UNITY_SHIFT = 6'd22;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [47:0] sample_time;
   } req_type;

   typedef struct packed {
      logic signed [55:0] value;
      logic               in_window;
      logic               saturated;
   } rsp_type;

   typedef logic [32:0] exp_rom_type [EXP_ROM_DEPTH];
   typedef logic [63:0] int_rom_type [EXP_INT_DEPTH];

   function automatic logic [63:0] mul_shr_c(input logic [63:0] a, input logic [63:0] b,
                                             input int unsigned s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (s - 1));
      p = p >> s;
      return p[63:0];
   endfunction

   function automatic logic [63:0] exp_series(input logic [63:0] a);
      logic [63:0] term;
      logic [63:0] sum;
      term = 64'd1 << 62;
      sum  = term;
      for (int k = 1; k <= 24; k++) begin
         term = mul_shr_c(term, a, 62) / 64'(k);
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] s;
      for (int i = 0; i < EXP_ROM_DEPTH; i++) begin
         s = exp_series(64'(i) << (62 - EXP_TABLE_BITS));
         rom[i] = 33'((s + (64'd1 << 29)) >> 30);
      end
      return rom;
   endfunction

   function automatic int_rom_type build_int_rom();
      int_rom_type rom;
      logic [63:0] e1;
      e1 = exp_series(64'd1 << 62);
      rom[0] = 64'd1 << 62;
      for (int k = 1; k < EXP_INT_DEPTH; k++) begin
         rom[k] = mul_shr_c(rom[k-1], e1, 62);
      end
      return rom;
   endfunction

endpackage

[rtl/core/rwe_mul.sv]
module rwe_mul (
   input  logic        clock,
   input  logic [39:0] a,
   input  logic [63:0] b,
   input  logic [5:0]  shift,
   output logic [63:0] product
);

   logic [61:0]  pp0_ff, pp1_ff, pp2_ff;
   logic [5:0]   shift_ff;
   logic [63:0]  product_ff;
   logic [105:0] sum;
   logic [105:0] shifted;

   always_ff @(posedge clock) begin
      pp0_ff   <= {22'd0, a} * {40'd0, b[21:0]};
      pp1_ff   <= {22'd0, a} * {40'd0, b[43:22]};
      pp2_ff   <= {22'd0, a} * {42'd0, b[63:44]};
      shift_ff <= shift;
   end

   // round half up, then drop the fraction
   always_comb begin
      sum = 106'(pp0_ff) + (106'(pp1_ff) << 22) + (106'(pp2_ff) << 44)
          + (106'd1 << (shift_ff - 6'd1));
      shifted = sum >> shift_ff;
   end

   always_ff @(posedge clock) begin
      product_ff <= shifted[63:0];
   end

   assign product = product_ff;

endmodule

[rtl/core/rwe_exp.sv]
module rwe_exp (
   input  logic        clock,
   input  logic [37:0] u,
   output logic [32:0] g
);

   localparam int unsigned FRAC   = rwe_pkg::EXP_FRAC_BITS;
   localparam int unsigned PROD_W = 33 + FRAC;
   localparam rwe_pkg::exp_rom_type FRAC_ROM = rwe_pkg::build_exp_rom();
   localparam rwe_pkg::int_rom_type INT_ROM  = rwe_pkg::build_int_rom();

   logic [rwe_pkg::EXP_ADDR_BITS-1:0] addr0, addr1;
   logic [32:0]       t0_ff, t1_ff, t0b_ff, interp_ff;
   logic [FRAC-1:0]   d_ff;
   logic [63:0]       en1_ff, en2_ff, en3_ff;
   logic [32:0]       diff;
   logic [PROD_W-1:0] prod_in, prod_ff, rnd;
   logic [32:0]       interp_in;
   logic [63:0]       g_full;

   assign addr0 = {1'b0, u[31:FRAC]};
   assign addr1 = addr0 + 1'b1;

   always_ff @(posedge clock) begin
      t0_ff  <= FRAC_ROM[addr0];
      t1_ff  <= FRAC_ROM[addr1];
      d_ff   <= u[FRAC-1:0];
      en1_ff <= INT_ROM[u[37:32]];
   end

   always_comb begin
      diff      = t0_ff - t1_ff;
      prod_in   = PROD_W'(diff) * PROD_W'(d_ff);
      rnd       = prod_ff + (PROD_W'(1) << (FRAC - 1));
      interp_in = t0b_ff - 33'(rnd >> FRAC);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      t0b_ff    <= t0_ff;
      en2_ff    <= en1_ff;
      interp_ff <= interp_in;
      en3_ff    <= en2_ff;
   end

   // scale exp of the negated fractional part by exp of the negated integer part
   rwe_mul u_mul (
      .clock   (clock),
      .a       (40'(interp_ff)),
      .b       (en3_ff),
      .shift   (6'd62),
      .product (g_full)
   );

   assign g = g_full[32:0];

endmodule

[rtl/core/ricker_wavelet_evaluator.sv]
// The result strobe is registered from the valid bit of the last pipeline stage.
// Throughput: one request per cycle, set by the fully pipelined multiply stages.
// busy is high only while reset is asserted; the receiver cannot stall.
// Reset (synchronous) clears all stage valid bits, the strobe and both registers.
module ricker_wavelet_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rwe_pkg::req_type req_data,
   output logic             rsp_valid,
   output rwe_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [47:0]      csr_write_data
);

   localparam int unsigned STAGES = 20;

   typedef struct packed {
      logic [1:0]  mode;
      logic        tneg;
      logic [47:0] pa;
      logic [63:0] plo;
      logic [49:0] m;
      logic        big;
      logic        live;
      logic        xneg;
      logic [33:0] ax32;
      logic [38:0] w;
      logic [38:0] c;
      logic        rneg;
      logic [32:0] g;
   } item_type;

   logic [31:0] f0_ff;
   logic [47:0] period_ff;
   logic        vld_ff [STAGES];
   item_type    stg_ff [STAGES];
   item_type    stg_in [STAGES];
   logic        rsp_valid_ff;
   rwe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [63:0] r_ay, r_u, r1, r2, r3, r4;
   logic [32:0] g_out;
   logic [39:0] a1, a2, a3, a4;
   logic [63:0] b1, b2, b3, b4;
   logic [5:0]  s1, s2, s3, s4;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff     <= '0;
         period_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            rwe_pkg::CSR_CENTRE_FREQUENCY: f0_ff     <= csr_write_data[31:0];
            rwe_pkg::CSR_PERIOD:           period_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [47:0] tmag;
      logic [50:0] msum;
      logic [53:0] m10;
      logic [50:0] ax, axr;
      logic [38:0] two_u;
      logic        wneg, cneg, win;

      for (int i = 1; i < STAGES; i++) begin
         stg_in[i] = stg_ff[i-1];
      end

      // take magnitude of t and form both halves of f0*|t|
      tmag = req_data.sample_time[47] ? (~req_data.sample_time + 48'd1)
                                      : req_data.sample_time;
      stg_in[0]      = stg_ff[0];
      stg_in[0].mode = req_data.mode;
      stg_in[0].tneg = req_data.sample_time[47];
      stg_in[0].pa   = 48'(f0_ff) * 48'(tmag[47:32]);
      stg_in[0].plo  = 64'(f0_ff) * 64'(tmag[31:0]);

      msum = 51'({stg_ff[0].pa[17:0], 32'd0}) + 51'(stg_ff[0].plo[49:0]);
      stg_in[1].m   = msum[49:0];
      stg_in[1].big = (stg_ff[0].pa[47:18] != '0) || (stg_ff[0].plo[63:50] != '0) || msum[50];

      // window test on 10*f0*t, then |x| rounded to Q.32
      m10 = (54'(stg_ff[1].m) << 3) + (54'(stg_ff[1].m) << 1);
      win = !stg_ff[1].big && (stg_ff[1].tneg ? (m10 < (54'd9 << 48))
                                              : (m10 < (54'd29 << 48)));
      case (stg_ff[1].mode)
         rwe_pkg::MODE_PRIMITIVE, rwe_pkg::MODE_WAVELET, rwe_pkg::MODE_DERIVATIVE:
            stg_in[2].live = win;
         default:
            stg_in[2].live = 1'b0;
      endcase
      if (stg_ff[1].tneg) begin
         ax = 51'(stg_ff[1].m) + (51'd1 << 48);
      end else if (51'(stg_ff[1].m) >= (51'd1 << 48)) begin
         ax = 51'(stg_ff[1].m) - (51'd1 << 48);
      end else begin
         ax = (51'd1 << 48) - 51'(stg_ff[1].m);
      end
      stg_in[2].xneg = stg_ff[1].tneg || (51'(stg_ff[1].m) < (51'd1 << 48));
      axr = ax + (51'd1 << 15);
      stg_in[2].ax32 = axr[49:16];

      two_u = {r_u[37:0], 1'b0};
      wneg  = two_u < (39'd1 << 32);
      cneg  = two_u > (39'd3 << 32);
      stg_in[7].w = wneg ? ((39'd1 << 32) - two_u) : (two_u - (39'd1 << 32));
      stg_in[7].c = cneg ? (two_u - (39'd3 << 32)) : ((39'd3 << 32) - two_u);
      case (stg_ff[6].mode)
         rwe_pkg::MODE_PRIMITIVE:  stg_in[7].rneg = !stg_ff[6].xneg;
         rwe_pkg::MODE_WAVELET:    stg_in[7].rneg = wneg;
         rwe_pkg::MODE_DERIVATIVE: stg_in[7].rneg = stg_ff[6].xneg ^ cneg;
         default:                  stg_in[7].rneg = 1'b0;
      endcase

      stg_in[12].g = g_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int i = 1; i < STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         stg_ff[i] <= stg_in[i];
      end
      rsp_data_ff <= rsp_data_in;
   end

   rwe_mul u_mul_ay (
      .clock   (clock),
      .a       (40'(rwe_pkg::PI_Q30)),
      .b       (64'(stg_ff[2].ax32)),
      .shift   (6'd30),
      .product (r_ay)
   );

   rwe_mul u_mul_u (
      .clock   (clock),
      .a       (r_ay[39:0]),
      .b       (r_ay),
      .shift   (6'd32),
      .product (r_u)
   );

   rwe_exp u_exp (
      .clock (clock),
      .u     (r_u[37:0]),
      .g     (g_out)
   );

   // per-mode operands; unused steps except p1 pass the value through unchanged
   always_comb begin
      case (stg_ff[11].mode)
         rwe_pkg::MODE_PRIMITIVE: begin
            a1 = 40'(g_out); b1 = 64'(stg_ff[11].ax32); s1 = 6'd32;
         end
         rwe_pkg::MODE_WAVELET: begin
            a1 = 40'(g_out); b1 = 64'(stg_ff[11].w); s1 = 6'd40;
         end
         rwe_pkg::MODE_DERIVATIVE: begin
            a1 = 40'(stg_ff[11].c); b1 = 64'(stg_ff[11].ax32); s1 = 6'd32;
         end
         default: begin
            a1 = rwe_pkg::UNITY_A; b1 = '0; s1 = rwe_pkg::UNITY_SHIFT;
         end
      endcase

      case (stg_ff[13].mode)
         rwe_pkg::MODE_PRIMITIVE: begin
            a2 = r1[39:0]; b2 = 64'(period_ff); s2 = 6'd40;
         end
         rwe_pkg::MODE_DERIVATIVE: begin
            a2 = 40'(stg_ff[13].g); b2 = r1; s2 = 6'd32;
         end
         default: begin
            a2 = rwe_pkg::UNITY_A; b2 = r1; s2 = rwe_pkg::UNITY_SHIFT;
         end
      endcase

      if (stg_ff[15].mode == rwe_pkg::MODE_DERIVATIVE) begin
         a3 = r2[39:0]; b3 = rwe_pkg::K2PI2; s3 = 6'd32;
      end else begin
         a3 = rwe_pkg::UNITY_A; b3 = r2; s3 = rwe_pkg::UNITY_SHIFT;
      end

      if (stg_ff[17].mode == rwe_pkg::MODE_DERIVATIVE) begin
         a4 = 40'(f0_ff); b4 = r3; s4 = 6'd24;
      end else begin
         a4 = rwe_pkg::UNITY_A; b4 = r3; s4 = rwe_pkg::UNITY_SHIFT;
      end
   end

   rwe_mul u_mul_p1 (.clock(clock), .a(a1), .b(b1), .shift(s1), .product(r1));
   rwe_mul u_mul_p2 (.clock(clock), .a(a2), .b(b2), .shift(s2), .product(r2));
   rwe_mul u_mul_p3 (.clock(clock), .a(a3), .b(b3), .shift(s3), .product(r3));
   rwe_mul u_mul_p4 (.clock(clock), .a(a4), .b(b4), .shift(s4), .product(r4));

   // apply sign and clip to the Q32.24 range
   always_comb begin
      logic [63:0] clip;
      logic        neg, sat;
      neg  = stg_ff[STAGES-1].rneg;
      clip = r4;
      sat  = 1'b0;
      if (!neg && (r4 > ((64'd1 << 55) - 64'd1))) begin
         clip = (64'd1 << 55) - 64'd1;
         sat  = 1'b1;
      end else if (neg && (r4 > (64'd1 << 55))) begin
         clip = 64'd1 << 55;
         sat  = 1'b1;
      end
      if (stg_ff[STAGES-1].live) begin
         rsp_data_in.value     = neg ? 56'(64'd0 - clip) : clip[55:0];
         rsp_data_in.in_window = 1'b1;
         rsp_data_in.saturated = sat;
      end else begin
         rsp_data_in.value     = '0;
         rsp_data_in.in_window = 1'b0;
         rsp_data_in.saturated = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
